/* rtl/spwg_pkg.sv */
// Shared constants, types and helper functions for the sonar pulse waveform generator.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package spwg_pkg;

    // Sizing
    localparam int TABLE_ADDR_BITS = 12;
    localparam int COUNT_BITS      = 16;
    localparam int SINE_BITS       = 16;

    localparam int PHASE_BITS   = 32;
    localparam int ACC_BITS     = 48;
    localparam int ACC_FRAC     = 16;
    localparam int ACC_HALF     = ACC_BITS / 2;
    localparam int FACTOR_BITS  = 32;
    localparam int FACTOR_FRAC  = 30;
    localparam int GEO_SHIFT    = FACTOR_FRAC - ACC_HALF;
    localparam int HP_BITS      = ACC_HALF + FACTOR_BITS;
    localparam int GEO_BITS     = HP_BITS - GEO_SHIFT + 1;

    localparam int QUARTER_BITS = TABLE_ADDR_BITS - 2;
    localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
    localparam int MAG_BITS     = SINE_BITS - 1;
    localparam int AMP_BITS     = 16;
    localparam int FRAC_BITS    = MAG_BITS + AMP_BITS;
    localparam int DAC_BITS     = 12;

    localparam logic [MAG_BITS-1:0] SINE_MAX = '1;

    // Quarter-wave table build
    localparam int X_BITS       = 32;
    localparam int Q30          = 30;
    localparam int PI_HALF_BITS = 31;
    localparam logic [PI_HALF_BITS-1:0] PI_HALF_Q30 = 31'd1686629713;
    localparam int TERM_BITS    = 4;
    localparam logic [TERM_BITS-1:0] TERMS = 4'd12;
    localparam int DIVISOR_BITS = 10;

    // Barker code
    localparam int CHIP_BITS       = 3;
    localparam int CHIP_COUNT_BITS = 16;
    localparam logic [CHIP_BITS-1:0] LAST_CHIP = 3'd6;
    localparam logic [7:0] BARKER_NEG_MASK = 8'h58;

    // Waveform modes
    localparam logic [1:0] MODE_LINEAR    = 2'd0;
    localparam logic [1:0] MODE_GEOMETRIC = 2'd1;
    localparam logic [1:0] MODE_BARKER    = 2'd2;

    // Register map
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 48;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_INC    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FACTOR       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHIP_LENGTH  = 3'd6;

    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 32'h4000_0000;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [COUNT_BITS-1:0]        sample_count;
        logic [PHASE_BITS-1:0]        start_inc;
        logic signed [ACC_BITS-1:0]   slope;
        logic [FACTOR_BITS-1:0]       factor;
        logic [AMP_BITS-1:0]          amplitude;
        logic [CHIP_COUNT_BITS-1:0]   chip_length;
    } cfg_t;

    // Per-sample control that travels beside the table read
    typedef struct packed {
        logic valid;   // sample produces a result
        logic neg;     // negate table magnitude
        logic zero;    // unused mode: force zero
        logic peak;    // quarter-wave apex, table data not used
        logic last;    // final sample of pulse
    } tap_t;

    // Taylor term divisor (2n)(2n+1)
    function automatic logic [DIVISOR_BITS-1:0] divisor(input logic [TERM_BITS-1:0] n);
        logic [DIVISOR_BITS-1:0] e;
        e = DIVISOR_BITS'({n, 1'b0});
        divisor = DIVISOR_BITS'(e * (e + 1'b1));
    endfunction

endpackage

`default_nettype wire

/* rtl/spwg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spwg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/spwg_cfg_regs.sv */
// Configuration register bank, written through the cfg transaction channel.
// Depends on spwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spwg_cfg_regs (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [spwg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [spwg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output spwg_pkg::cfg_t                             cfg
);

    spwg_pkg::cfg_t cfg_reg;
    spwg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                spwg_pkg::REG_MODE:
                    cfg_next.mode = cfg_data[1:0];
                spwg_pkg::REG_SAMPLE_COUNT:
                    cfg_next.sample_count = cfg_data[spwg_pkg::COUNT_BITS-1:0];
                spwg_pkg::REG_START_INC:
                    cfg_next.start_inc = cfg_data[spwg_pkg::PHASE_BITS-1:0];
                spwg_pkg::REG_SLOPE:
                    cfg_next.slope = $signed(cfg_data[spwg_pkg::ACC_BITS-1:0]);
                spwg_pkg::REG_FACTOR:
                    cfg_next.factor = cfg_data[spwg_pkg::FACTOR_BITS-1:0];
                spwg_pkg::REG_AMPLITUDE:
                    cfg_next.amplitude = cfg_data[spwg_pkg::AMP_BITS-1:0];
                spwg_pkg::REG_CHIP_LENGTH:
                    cfg_next.chip_length = cfg_data[spwg_pkg::CHIP_COUNT_BITS-1:0];
                default:
                    cfg_next = cfg_reg;   // index past the map: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg             <= '0;
            cfg_reg.factor      <= spwg_pkg::FACTOR_RESET;
            cfg_reg.chip_length <= spwg_pkg::CHIP_COUNT_BITS'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/spwg_sine_fill.sv */
// Post-reset sequencer that computes the quarter-wave sine table (Taylor series,
// Q30) one entry at a time and writes it into the table RAM. Depends on spwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spwg_sine_fill (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    output logic                                     wr_en,
    output logic [spwg_pkg::QUARTER_BITS-1:0]        wr_addr,
    output logic [spwg_pkg::MAG_BITS-1:0]            wr_data,
    output logic                                     done
);

    localparam int STEP_BITS = $clog2(spwg_pkg::X_BITS);
    localparam int XPROD_BITS = spwg_pkg::PI_HALF_BITS + spwg_pkg::QUARTER_BITS;
    localparam int SPROD_BITS = spwg_pkg::X_BITS + spwg_pkg::MAG_BITS;
    localparam int SV_BITS = SPROD_BITS - spwg_pkg::Q30;

    localparam logic [2:0] ST_X     = 3'd0;
    localparam logic [2:0] ST_MUL1  = 3'd1;
    localparam logic [2:0] ST_MUL2  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]                          state_reg, state_next;
    logic [spwg_pkg::QUARTER_BITS-1:0]   r_reg, r_next;
    logic [spwg_pkg::TERM_BITS-1:0]      n_reg, n_next;
    logic [STEP_BITS-1:0]                step_reg, step_next;
    logic [spwg_pkg::X_BITS-1:0]         x_reg, x_next;
    logic [spwg_pkg::X_BITS-1:0]         t_reg, t_next;
    logic [spwg_pkg::X_BITS-1:0]         sum_reg, sum_next;
    logic [spwg_pkg::DIVISOR_BITS-1:0]   rem_reg, rem_next;
    logic [spwg_pkg::MAG_BITS-1:0]       v_reg, v_next;

    logic [XPROD_BITS-1:0]               xprod;
    logic [spwg_pkg::X_BITS-1:0]         x_init;
    logic [2*spwg_pkg::X_BITS-1:0]       mul_full;
    logic [spwg_pkg::X_BITS-1:0]         t_mul;
    logic [spwg_pkg::DIVISOR_BITS:0]     rem_sh;
    logic [spwg_pkg::DIVISOR_BITS:0]     dvs;
    logic                                quo_bit;
    logic [SPROD_BITS-1:0]               sprod;
    logic [SV_BITS-1:0]                  sv;

    // x = angle in Q30 for entry r
    assign xprod    = spwg_pkg::PI_HALF_Q30 * r_reg;
    assign x_init   = spwg_pkg::X_BITS'(xprod >> spwg_pkg::QUARTER_BITS);

    // t = (t * x) >> 30; term magnitudes stay below 2^32
    assign mul_full = t_reg * x_reg;
    assign t_mul    = spwg_pkg::X_BITS'(mul_full >> spwg_pkg::Q30);

    // restoring divide, one quotient bit per cycle, quotient shifts into t
    assign dvs      = {1'b0, spwg_pkg::divisor(n_reg)};
    assign rem_sh   = {rem_reg, t_reg[spwg_pkg::X_BITS-1]};
    assign quo_bit  = (rem_sh >= dvs);

    // round(sum * SINE_MAX / 2^30), clamped
    assign sprod    = sum_reg * spwg_pkg::SINE_MAX
                      + (SPROD_BITS'(1) << (spwg_pkg::Q30 - 1));
    assign sv       = SV_BITS'(sprod >> spwg_pkg::Q30);

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        t_next     = t_reg;
        sum_next   = sum_reg;
        rem_next   = rem_reg;
        v_next     = v_reg;
        unique case (state_reg)
            ST_X:
            begin
                x_next     = x_init;
                t_next     = x_init;
                sum_next   = x_init;
                n_next     = spwg_pkg::TERM_BITS'(1);
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                t_next     = t_mul;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                t_next     = t_mul;
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                t_next    = {t_reg[spwg_pkg::X_BITS-2:0], quo_bit};
                rem_next  = quo_bit ? spwg_pkg::DIVISOR_BITS'(rem_sh - dvs)
                                    : spwg_pkg::DIVISOR_BITS'(rem_sh);
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(spwg_pkg::X_BITS - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                sum_next = n_reg[0] ? (sum_reg - t_reg) : (sum_reg + t_reg);
                if (n_reg == spwg_pkg::TERMS)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_SCALE:
            begin
                v_next     = (sv > SV_BITS'(spwg_pkg::SINE_MAX))
                             ? spwg_pkg::SINE_MAX : spwg_pkg::MAG_BITS'(sv);
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (r_reg == '1)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = ST_X;
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_X;
            r_reg     <= '0;
            n_reg     <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            r_reg     <= r_next;
            n_reg     <= n_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        t_reg   <= t_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        v_reg   <= v_next;
    end

    assign wr_en   = (state_reg == ST_WRITE);
    assign wr_addr = r_reg;
    assign wr_data = v_reg;
    assign done    = (state_reg == ST_DONE);

endmodule

`default_nettype wire

/* rtl/spwg_phase_core.sv */
// Per-sample state update: phase and increment recurrences for the three
// waveform modes, pulse and chip counting, table address folding.
// Depends on spwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spwg_phase_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  spwg_pkg::cfg_t                         cfg,
    input  wire logic                              item_accept,
    input  wire logic                              restart,
    output logic [spwg_pkg::QUARTER_BITS-1:0]      rom_addr,
    output spwg_pkg::tap_t                         tap
);

    logic [spwg_pkg::PHASE_BITS-1:0]      phase_reg, phase_next, phase_e;
    logic [spwg_pkg::ACC_BITS-1:0]        inc_reg, inc_next, inc_e;
    logic [spwg_pkg::COUNT_BITS-1:0]      idx_reg, idx_next, idx_e;
    logic [spwg_pkg::CHIP_COUNT_BITS-1:0] chip_cnt_reg, chip_cnt_next, chip_cnt_e;
    logic [spwg_pkg::CHIP_BITS-1:0]       chip_reg, chip_next, chip_e;
    logic                                 active_reg, active_next, active_e;

    logic [spwg_pkg::CHIP_COUNT_BITS-1:0] chip_len;
    logic [spwg_pkg::CHIP_COUNT_BITS-1:0] chip_cnt_inc;
    logic [spwg_pkg::COUNT_BITS:0]        idx_inc;
    logic                                 last;
    logic [spwg_pkg::PHASE_BITS-1:0]      read_phase;
    logic                                 barker_neg;
    logic                                 unused_mode;

    // geometric increment scale, split into two 24 x 32 products
    logic [spwg_pkg::ACC_HALF-1:0]        geo_ah, geo_al;
    logic [spwg_pkg::HP_BITS-1:0]         geo_hp, geo_lp;
    logic [spwg_pkg::HP_BITS:0]           geo_low;
    logic [spwg_pkg::GEO_BITS-1:0]        geo_sum;
    logic [spwg_pkg::ACC_BITS-1:0]        geo_inc;

    logic [spwg_pkg::TABLE_ADDR_BITS-1:0] tbl_addr;
    logic [1:0]                           quad;
    logic [spwg_pkg::QUARTER_BITS-1:0]    tbl_r;

    assign geo_ah  = inc_e[spwg_pkg::ACC_BITS-1:spwg_pkg::ACC_HALF];
    assign geo_al  = inc_e[spwg_pkg::ACC_HALF-1:0];
    assign geo_hp  = geo_ah * cfg.factor;
    assign geo_lp  = geo_al * cfg.factor;
    assign geo_low = {geo_hp[spwg_pkg::GEO_SHIFT-1:0], {spwg_pkg::ACC_HALF{1'b0}}}
                     + geo_lp;
    assign geo_sum = spwg_pkg::GEO_BITS'(geo_hp >> spwg_pkg::GEO_SHIFT)
                     + spwg_pkg::GEO_BITS'(geo_low >> spwg_pkg::FACTOR_FRAC);
    // saturate at full scale of the accumulator
    assign geo_inc = (|geo_sum[spwg_pkg::GEO_BITS-1:spwg_pkg::ACC_BITS])
                     ? '1 : geo_sum[spwg_pkg::ACC_BITS-1:0];

    always_comb
    begin
        // restart reloads the pulse before the step is taken
        phase_e    = phase_reg;
        inc_e      = inc_reg;
        idx_e      = idx_reg;
        chip_cnt_e = chip_cnt_reg;
        chip_e     = chip_reg;
        active_e   = active_reg;
        if (restart)
        begin
            phase_e    = '0;
            inc_e      = {cfg.start_inc, {spwg_pkg::ACC_FRAC{1'b0}}};
            idx_e      = '0;
            chip_cnt_e = '0;
            chip_e     = '0;
            active_e   = (cfg.sample_count != '0);
        end

        chip_len     = (cfg.chip_length == '0) ? spwg_pkg::CHIP_COUNT_BITS'(1)
                                               : cfg.chip_length;
        chip_cnt_inc = chip_cnt_e + 1'b1;
        idx_inc      = {1'b0, idx_e} + 1'b1;
        last         = (idx_inc >= {1'b0, cfg.sample_count});

        phase_next    = phase_e;
        inc_next      = inc_e;
        idx_next      = idx_e;
        chip_cnt_next = chip_cnt_e;
        chip_next     = chip_e;
        active_next   = active_e;
        read_phase    = phase_e;
        barker_neg    = 1'b0;
        unused_mode   = 1'b0;

        if (active_e)
        begin
            unique case (cfg.mode)
                spwg_pkg::MODE_LINEAR:
                begin
                    // sample, then phase += inc, then inc += slope
                    phase_next = phase_e
                                 + inc_e[spwg_pkg::ACC_BITS-1 -: spwg_pkg::PHASE_BITS];
                    inc_next   = inc_e + $unsigned(cfg.slope);
                end
                spwg_pkg::MODE_GEOMETRIC:
                begin
                    // scale (not on sample zero), phase += inc, then sample
                    inc_next   = (idx_e != '0) ? geo_inc : inc_e;
                    phase_next = phase_e
                                 + inc_next[spwg_pkg::ACC_BITS-1 -: spwg_pkg::PHASE_BITS];
                    read_phase = phase_next;
                end
                spwg_pkg::MODE_BARKER:
                begin
                    barker_neg = spwg_pkg::BARKER_NEG_MASK[chip_e];
                    phase_next = phase_e + cfg.start_inc;
                    // last chip runs to the end of the pulse
                    if (chip_e < spwg_pkg::LAST_CHIP)
                    begin
                        if (chip_cnt_inc >= chip_len)
                        begin
                            chip_cnt_next = '0;
                            chip_next     = chip_e + 1'b1;
                        end
                        else
                        begin
                            chip_cnt_next = chip_cnt_inc;
                        end
                    end
                end
                default:
                begin
                    // unused mode: mid-scale output, phase frozen
                    unused_mode = 1'b1;
                end
            endcase
            idx_next    = idx_inc[spwg_pkg::COUNT_BITS-1:0];
            active_next = !last;
        end
    end

    // fold the full-wave address onto the quarter table
    assign tbl_addr = read_phase[spwg_pkg::PHASE_BITS-1 -: spwg_pkg::TABLE_ADDR_BITS];
    assign quad     = tbl_addr[spwg_pkg::TABLE_ADDR_BITS-1 -: 2];
    assign tbl_r    = tbl_addr[spwg_pkg::QUARTER_BITS-1:0];
    assign rom_addr = quad[0] ? (spwg_pkg::QUARTER_BITS'(0) - tbl_r) : tbl_r;

    assign tap.valid = active_e;
    assign tap.neg   = quad[1] ^ barker_neg;
    assign tap.zero  = unused_mode;
    assign tap.peak  = quad[0] && (tbl_r == '0);
    assign tap.last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            inc_reg      <= '0;
            idx_reg      <= '0;
            chip_cnt_reg <= '0;
            chip_reg     <= '0;
            active_reg   <= 1'b0;
        end
        else if (item_accept)
        begin
            phase_reg    <= phase_next;
            inc_reg      <= inc_next;
            idx_reg      <= idx_next;
            chip_cnt_reg <= chip_cnt_next;
            chip_reg     <= chip_next;
            active_reg   <= active_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/spwg_dac_path.sv */
// Output pipeline: table data stage, amplitude multiply stage and DAC code
// output register, with per-stage valid/stall handling. Depends on spwg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spwg_dac_path (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  spwg_pkg::tap_t                         tap,
    input  wire logic [spwg_pkg::MAG_BITS-1:0]     rom_data,
    input  wire logic [spwg_pkg::AMP_BITS-1:0]     amplitude,
    input  wire logic                              out_ready,
    output logic                                   can_load,
    output logic                                   out_valid,
    output logic [spwg_pkg::DAC_BITS-1:0]          dac_code,
    output logic                                   last_sample
);

    localparam int U_BITS = spwg_pkg::FRAC_BITS + 1;
    localparam int SCALED_BITS = U_BITS + spwg_pkg::DAC_BITS;
    localparam logic [U_BITS-1:0] ONE = {1'b1, {spwg_pkg::FRAC_BITS{1'b0}}};

    spwg_pkg::tap_t                   a_tap_reg, a_tap_next;
    logic                             b_valid_reg, b_valid_next;
    logic                             b_neg_reg, b_last_reg;
    logic [spwg_pkg::FRAC_BITS-1:0]   b_prod_reg;
    logic                             o_valid_reg, o_valid_next;
    logic [spwg_pkg::DAC_BITS-1:0]    o_code_reg;
    logic                             o_last_reg;

    logic                             load_b, load_o;
    logic [spwg_pkg::MAG_BITS-1:0]    mag;
    logic [spwg_pkg::FRAC_BITS-1:0]   prod;
    logic [U_BITS-1:0]                u;
    logic [SCALED_BITS-1:0]           scaled;

    assign load_o   = b_valid_reg && (!o_valid_reg || out_ready);
    assign load_b   = a_tap_reg.valid && (!b_valid_reg || load_o);
    assign can_load = !a_tap_reg.valid || load_b;

    // |v * amplitude| < 2^FRAC_BITS, so the +-1 clamp never engages
    assign mag  = a_tap_reg.zero ? '0 : (a_tap_reg.peak ? spwg_pkg::SINE_MAX : rom_data);
    assign prod = mag * amplitude;

    // (s + 1) * 4095 / 2, truncated; stays below 4095
    assign u      = b_neg_reg ? (ONE - {1'b0, b_prod_reg}) : (ONE + {1'b0, b_prod_reg});
    assign scaled = {u, {spwg_pkg::DAC_BITS{1'b0}}} - {{spwg_pkg::DAC_BITS{1'b0}}, u};

    always_comb
    begin
        a_tap_next = a_tap_reg;
        if (load)
        begin
            a_tap_next = tap;
        end
        else if (load_b)
        begin
            a_tap_next.valid = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (load_b)
        begin
            b_valid_next = 1'b1;
        end
        else if (load_o)
        begin
            b_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (load_o)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tap_reg   <= '0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_tap_reg   <= a_tap_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_neg_reg  <= a_tap_reg.neg;
            b_last_reg <= a_tap_reg.last;
            b_prod_reg <= prod;
        end
        if (load_o)
        begin
            o_code_reg <= scaled[SCALED_BITS-1 -: spwg_pkg::DAC_BITS];
            o_last_reg <= b_last_reg;
        end
    end

    assign out_valid   = o_valid_reg;
    assign dac_code    = o_code_reg;
    assign last_sample = o_last_reg;

endmodule

`default_nettype wire

/* rtl/sonar_pulse_waveform_generator_top.sv */
// Top level of the sonar pulse waveform generator (DDS chirp / sweep / Barker-7).
// Depends on spwg_pkg, spwg_cfg_regs, spwg_sine_fill, spwg_ram, spwg_phase_core,
// spwg_dac_path.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): one register write
//   per transaction; cfg_ready is always high, also during the table build.
//   Write registers only while no sample is in flight.
//   in channel (in_valid/in_ready, restart): one transaction per sample tick.
//   restart = 1 starts a pulse at sample zero, 0 advances the running pulse.
//   A tick with no pulse running (or a restart with zero sample count) is
//   accepted and produces nothing.
//   out channel (out_valid/out_ready, dac_code, last_sample): one transaction
//   per produced sample; last_sample flags the final sample of the pulse.
// Timing:
//   One input transaction per clock, sustained while out_ready stays high.
//   The phase/increment state loop (geometric multiply plus phase add in the
//   worst case) is combinational between the state registers. After its input
//   transaction a result passes the table RAM read, the amplitude multiply stage
//   and the DAC output register. When out_ready is low the three stages fill up;
//   in_ready drops only when all are occupied and nothing moves.
// Reset:
//   rst_n clears all control state and the config registers to their defaults,
//   then the quarter-wave sine table of 1024 entries is built into RAM, during
//   which in_ready stays low.
`timescale 1ns / 1ps
`default_nettype none

module sonar_pulse_waveform_generator_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [spwg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [spwg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // sample tick channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  restart,
    // DAC sample channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [spwg_pkg::DAC_BITS-1:0]              dac_code,
    output logic                                       last_sample
);

    spwg_pkg::cfg_t                      cfg;
    spwg_pkg::tap_t                      tap;

    logic                                fill_wr_en;
    logic [spwg_pkg::QUARTER_BITS-1:0]   fill_wr_addr;
    logic [spwg_pkg::MAG_BITS-1:0]       fill_wr_data;
    logic                                fill_done;

    logic [spwg_pkg::QUARTER_BITS-1:0]   rom_addr;
    logic [spwg_pkg::MAG_BITS-1:0]       rom_data;
    logic                                pipe_can_load;
    logic                                item_accept;

    // config writes never stall
    assign cfg_ready = 1'b1;

    // ticks are held off until the sine table is built
    assign in_ready    = fill_done && pipe_can_load;
    assign item_accept = in_valid && in_ready;

    spwg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spwg_sine_fill u_sine_fill (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .done    (fill_done)
    );

    // quarter-wave magnitude table, read once per accepted tick
    spwg_ram #(
        .WIDTH (spwg_pkg::MAG_BITS),
        .DEPTH (spwg_pkg::QUARTER_SIZE)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_en   (item_accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    spwg_phase_core u_phase_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_accept (item_accept),
        .restart     (restart),
        .rom_addr    (rom_addr),
        .tap         (tap)
    );

    spwg_dac_path u_dac_path (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (item_accept),
        .tap         (tap),
        .rom_data    (rom_data),
        .amplitude   (cfg.amplitude),
        .out_ready   (out_ready),
        .can_load    (pipe_can_load),
        .out_valid   (out_valid),
        .dac_code    (dac_code),
        .last_sample (last_sample)
    );

endmodule

`default_nettype wire

/* rtl/spwg_checker.sv */
// Port-level checker for the waveform generator top, attached by bind.
// Depends on spwg_pkg and sonar_pulse_waveform_generator_top.
`timescale 1ns / 1ps
`default_nettype none

module spwg_checker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    input  wire logic                                  cfg_ready,
    input  wire logic [spwg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [spwg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_ready,
    input  wire logic                                  restart,
    input  wire logic                                  out_valid,
    input  wire logic                                  out_ready,
    input  wire logic [spwg_pkg::DAC_BITS-1:0]         dac_code,
    input  wire logic                                  last_sample
);

    // a stalled result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dac_code) && $stable(last_sample))
        else $error("output transaction changed while stalled");

    // table build keeps ticks off and the pipeline empty right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) |-> !in_ready && !out_valid)
        else $error("tick channel or output active right after reset");

    // ready is not withdrawn without a tick transaction
    a_ready_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("in_ready dropped with no transaction taken");

endmodule

bind sonar_pulse_waveform_generator_top spwg_checker u_spwg_checker (.*);

`default_nettype wire
